FILE: rtl/nec_ir_pkg.sv
// shared types, phase codes, timing windows and reset values for the nec ir frame decoder
package nec_ir_pkg;

    localparam int NUM_KEYS_DEF   = 6;
    localparam int FRAME_BITS_DEF = 32;
    localparam int KEY_REGS       = 6;

    localparam int DUR_W   = 16;
    localparam int WORD_W  = 16;
    localparam int CODE_W  = 32;
    localparam int IDX_W   = 3;
    localparam int CNT_W   = 6;
    localparam int HOLD_W  = 8;
    localparam int PHASE_W = 4;

    // receive phase codes
    localparam logic [PHASE_W-1:0] PH_LEAD    = 4'd0;
    localparam logic [PHASE_W-1:0] PH_SPACE   = 4'd1;
    localparam logic [PHASE_W-1:0] PH_RSPACE  = 4'd2;
    localparam logic [PHASE_W-1:0] PH_BITHEAD = 4'd3;
    localparam logic [PHASE_W-1:0] PH_END     = 4'd6;
    localparam logic [PHASE_W-1:0] PH_NEXT    = 4'd7;
    localparam logic [PHASE_W-1:0] PH_IDLE    = 4'd8;

    // configuration register indexes
    localparam logic [IDX_W-1:0] CFG_REPEAT_START = 3'd6;

    // timing windows in microseconds, bounds exclusive
    localparam logic [DUR_W-1:0] LEAD_LO   = 16'd7200;
    localparam logic [DUR_W-1:0] LEAD_HI   = 16'd10800;
    localparam logic [DUR_W-1:0] SPACE_LO  = 16'd3600;
    localparam logic [DUR_W-1:0] SPACE_HI  = 16'd5400;
    localparam logic [DUR_W-1:0] RSPACE_LO = 16'd1800;
    localparam logic [DUR_W-1:0] RSPACE_HI = 16'd2700;
    localparam logic [DUR_W-1:0] SHORT_LO  = 16'd450;
    localparam logic [DUR_W-1:0] SHORT_HI  = 16'd675;
    localparam logic [DUR_W-1:0] ONE_LO    = 16'd1350;
    localparam logic [DUR_W-1:0] ONE_HI    = 16'd2025;

    localparam logic [HOLD_W-1:0] REPEAT_START_RST = 8'd12;

    localparam logic [CODE_W-1:0] KEY_RESET [KEY_REGS] = '{
        32'hF609BF00, 32'hF50ABF00, 32'hF708BF00,
        32'hF906BF00, 32'hF20DBF00, 32'hFA05BF00
    };

    typedef struct packed {
        logic               key_available;
        logic               key_held;
        logic [IDX_W-1:0]   key_index;
        logic [WORD_W-1:0]  rx_address;
        logic [WORD_W-1:0]  rx_command;
    } t_result;

    function automatic logic in_window(
        input logic [DUR_W-1:0] d,
        input logic [DUR_W-1:0] lo,
        input logic [DUR_W-1:0] hi
    );
        return (d > lo) && (d < hi);
    endfunction

endpackage

FILE: rtl/nec_ir_frame_decoder_core.sv
// nec infrared frame decoder: phase machine, key match and output buffer
//
// Input channel (i_in_valid / o_in_ready) carries one event per transaction:
// i_func = 0 is a pin edge with the duration of the ended level and the new
// pin level, i_func = 1 is a timer overflow tick. Every accepted event gives
// exactly one result on the output channel (o_out_valid / i_out_ready):
// key-available, key-held, the last stored address and command, and the
// index of the first configured key code that equals them.
// The configuration channel (i_cfg_valid / o_cfg_ready, always ready) writes
// key codes 0..5 and the repeat countdown start at index 6; other indexes
// are ignored. Write it only while no results are outstanding.
// The decoder state and the result are registered at the accepting edge.
// One event per cycle is sustained while o_in_ready is high, set by the
// combinational next-state and key compare logic.
// A two-entry output buffer absorbs receiver stalls; o_in_ready drops only
// when both entries hold results not yet taken.
// Synchronous reset empties the buffer, puts the machine in idle, clears the
// stored frame and countdown and loads the default key codes.
module nec_ir_frame_decoder_core #(
    parameter int NUM_KEYS   = nec_ir_pkg::NUM_KEYS_DEF,
    parameter int FRAME_BITS = nec_ir_pkg::FRAME_BITS_DEF
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_in_valid,
    output logic                              o_in_ready,
    input  logic                              i_func,
    input  logic [nec_ir_pkg::DUR_W-1:0]      i_duration_us,
    input  logic                              i_pin_level,
    output logic                              o_out_valid,
    input  logic                              i_out_ready,
    output logic                              o_key_available,
    output logic                              o_key_held,
    output logic [nec_ir_pkg::IDX_W-1:0]      o_key_index,
    output logic [nec_ir_pkg::WORD_W-1:0]     o_rx_address,
    output logic [nec_ir_pkg::WORD_W-1:0]     o_rx_command,
    input  logic                              i_cfg_valid,
    output logic                              o_cfg_ready,
    input  logic [nec_ir_pkg::IDX_W-1:0]      i_cfg_index,
    input  logic [nec_ir_pkg::CODE_W-1:0]     i_cfg_data
);

    localparam int KEY_CNT = (NUM_KEYS < nec_ir_pkg::KEY_REGS) ? NUM_KEYS
                                                               : nec_ir_pkg::KEY_REGS;
    localparam logic [nec_ir_pkg::CNT_W-1:0] FRAME_CNT = nec_ir_pkg::CNT_W'(FRAME_BITS);

    logic [nec_ir_pkg::CODE_W-1:0]  r_key_code [nec_ir_pkg::KEY_REGS];
    logic [nec_ir_pkg::HOLD_W-1:0]  r_repeat_start;

    logic [nec_ir_pkg::PHASE_W-1:0] r_phase, n_phase;
    logic [nec_ir_pkg::CNT_W-1:0]   r_bit_count, n_bit_count;
    logic [nec_ir_pkg::CODE_W-1:0]  r_shift, n_shift;
    logic                           r_frame_ready, n_frame_ready;
    logic [nec_ir_pkg::WORD_W-1:0]  r_address, n_address;
    logic [nec_ir_pkg::WORD_W-1:0]  r_command, n_command;
    logic [nec_ir_pkg::HOLD_W-1:0]  r_hold, n_hold;

    nec_ir_pkg::t_result            r_out, r_skid, n_result;
    logic                           r_out_valid, r_skid_valid;

    logic                           in_acc, out_pop;
    logic                           push_one, push_bit;
    logic [nec_ir_pkg::CNT_W-1:0]   bit_count_inc;
    logic [nec_ir_pkg::CODE_W-1:0]  shift_set;
    logic [nec_ir_pkg::CODE_W-1:0]  match_code;
    logic [nec_ir_pkg::IDX_W-1:0]   match_idx;

    assign o_in_ready  = !r_skid_valid;
    assign o_cfg_ready = 1'b1;
    assign in_acc      = i_in_valid && o_in_ready;
    assign out_pop     = r_out_valid && i_out_ready;

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < nec_ir_pkg::KEY_REGS; i++) begin
                r_key_code[i] <= nec_ir_pkg::KEY_RESET[i];
            end
            r_repeat_start <= nec_ir_pkg::REPEAT_START_RST;
        end else if (i_cfg_valid) begin
            for (int i = 0; i < nec_ir_pkg::KEY_REGS; i++) begin
                if (i_cfg_index == nec_ir_pkg::IDX_W'(i)) begin
                    r_key_code[i] <= i_cfg_data;
                end
            end
            if (i_cfg_index == nec_ir_pkg::CFG_REPEAT_START) begin
                r_repeat_start <= i_cfg_data[nec_ir_pkg::HOLD_W-1:0];
            end
        end
    end

    assign bit_count_inc = r_bit_count + 1'b1;
    assign shift_set     = r_shift | (nec_ir_pkg::CODE_W'(1) << r_bit_count[4:0]);

    // next decoder state for the presented event
    always_comb begin
        n_phase       = r_phase;
        n_bit_count   = r_bit_count;
        n_shift       = r_shift;
        n_frame_ready = r_frame_ready;
        n_address     = r_address;
        n_command     = r_command;
        n_hold        = r_hold;
        push_one      = 1'b0;
        push_bit      = 1'b0;

        if (i_func) begin
            if (r_hold == '0) begin
                n_frame_ready = 1'b0;
            end else begin
                n_hold = r_hold - 1'b1;
            end
            if (r_phase != nec_ir_pkg::PH_IDLE) begin
                n_phase     = nec_ir_pkg::PH_IDLE;
                n_bit_count = '0;
                n_shift     = '0;
            end
        end else begin
            case (r_phase)
                nec_ir_pkg::PH_LEAD: begin
                    if (!i_pin_level && nec_ir_pkg::in_window(i_duration_us,
                            nec_ir_pkg::SPACE_LO, nec_ir_pkg::SPACE_HI)) begin
                        n_phase = nec_ir_pkg::PH_SPACE;
                    end else if (!i_pin_level && nec_ir_pkg::in_window(i_duration_us,
                            nec_ir_pkg::RSPACE_LO, nec_ir_pkg::RSPACE_HI)) begin
                        n_phase = nec_ir_pkg::PH_RSPACE;
                    end else begin
                        n_phase     = nec_ir_pkg::PH_IDLE;
                        n_bit_count = '0;
                        n_shift     = '0;
                    end
                end
                nec_ir_pkg::PH_SPACE, nec_ir_pkg::PH_NEXT: begin
                    // the data space loads the hold countdown whatever follows
                    if (r_phase == nec_ir_pkg::PH_SPACE) begin
                        n_hold = r_repeat_start;
                    end
                    if (i_pin_level && nec_ir_pkg::in_window(i_duration_us,
                            nec_ir_pkg::SHORT_LO, nec_ir_pkg::SHORT_HI)) begin
                        n_phase = nec_ir_pkg::PH_BITHEAD;
                    end else begin
                        n_phase     = nec_ir_pkg::PH_IDLE;
                        n_bit_count = '0;
                        n_shift     = '0;
                    end
                end
                nec_ir_pkg::PH_RSPACE: begin
                    if (i_pin_level && nec_ir_pkg::in_window(i_duration_us,
                            nec_ir_pkg::SHORT_LO, nec_ir_pkg::SHORT_HI)) begin
                        n_hold      = r_repeat_start;
                        n_phase     = nec_ir_pkg::PH_IDLE;
                        n_bit_count = '0;
                        n_shift     = '0;
                    end
                end
                nec_ir_pkg::PH_BITHEAD: begin
                    if (!i_pin_level && nec_ir_pkg::in_window(i_duration_us,
                            nec_ir_pkg::ONE_LO, nec_ir_pkg::ONE_HI)) begin
                        push_bit = 1'b1;
                        push_one = 1'b1;
                    end else if (!i_pin_level && nec_ir_pkg::in_window(i_duration_us,
                            nec_ir_pkg::SHORT_LO, nec_ir_pkg::SHORT_HI)) begin
                        push_bit = 1'b1;
                    end
                    if (push_bit) begin
                        // bits arrive lsb first
                        n_shift     = push_one ? shift_set : r_shift;
                        n_bit_count = bit_count_inc;
                        n_phase     = (bit_count_inc >= FRAME_CNT) ? nec_ir_pkg::PH_END
                                                                   : nec_ir_pkg::PH_NEXT;
                    end else begin
                        n_phase     = nec_ir_pkg::PH_IDLE;
                        n_bit_count = '0;
                        n_shift     = '0;
                    end
                end
                nec_ir_pkg::PH_END: begin
                    if (i_pin_level && nec_ir_pkg::in_window(i_duration_us,
                            nec_ir_pkg::SHORT_LO, nec_ir_pkg::SHORT_HI)) begin
                        n_address     = r_shift[nec_ir_pkg::WORD_W-1:0];
                        n_command     = r_shift[nec_ir_pkg::CODE_W-1:nec_ir_pkg::WORD_W];
                        n_frame_ready = 1'b1;
                        n_phase       = nec_ir_pkg::PH_IDLE;
                        n_bit_count   = '0;
                        n_shift       = '0;
                    end
                end
                default: begin
                    // idle and unused codes wait for a lead pulse
                    if (i_pin_level && nec_ir_pkg::in_window(i_duration_us,
                            nec_ir_pkg::LEAD_LO, nec_ir_pkg::LEAD_HI)) begin
                        n_phase = nec_ir_pkg::PH_LEAD;
                    end else begin
                        n_phase = nec_ir_pkg::PH_IDLE;
                    end
                end
            endcase
        end
    end

    // first configured key equal to the updated stored frame
    assign match_code = {n_command, n_address};

    always_comb begin
        match_idx = nec_ir_pkg::IDX_W'(KEY_CNT);
        for (int i = KEY_CNT - 1; i >= 0; i--) begin
            if (r_key_code[i] == match_code) begin
                match_idx = nec_ir_pkg::IDX_W'(i);
            end
        end
    end

    always_comb begin
        n_result.key_available = n_frame_ready;
        n_result.key_held      = (n_hold != '0);
        n_result.key_index     = match_idx;
        n_result.rx_address    = n_address;
        n_result.rx_command    = n_command;
    end

    // decoder state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase       <= nec_ir_pkg::PH_IDLE;
            r_bit_count   <= '0;
            r_shift       <= '0;
            r_frame_ready <= 1'b0;
            r_address     <= '0;
            r_command     <= '0;
            r_hold        <= '0;
        end else if (in_acc) begin
            r_phase       <= n_phase;
            r_bit_count   <= n_bit_count;
            r_shift       <= n_shift;
            r_frame_ready <= n_frame_ready;
            r_address     <= n_address;
            r_command     <= n_command;
            r_hold        <= n_hold;
        end
    end

    // two-entry output buffer: head register plus skid entry
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else if (r_skid_valid) begin
            if (out_pop) begin
                r_out_valid  <= 1'b1;
                r_skid_valid <= 1'b0;
            end
        end else if (in_acc) begin
            if (!r_out_valid || out_pop) begin
                r_out_valid <= 1'b1;
            end else begin
                r_skid_valid <= 1'b1;
            end
        end else if (out_pop) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_skid_valid) begin
            if (out_pop) begin
                r_out <= r_skid;
            end
        end else if (in_acc) begin
            if (!r_out_valid || out_pop) begin
                r_out <= n_result;
            end else begin
                r_skid <= n_result;
            end
        end
    end

    assign o_out_valid     = r_out_valid;
    assign o_key_available = r_out.key_available;
    assign o_key_held      = r_out.key_held;
    assign o_key_index     = r_out.key_index;
    assign o_rx_address    = r_out.rx_address;
    assign o_rx_command    = r_out.rx_command;

endmodule

FILE: tb/sv/nec_ir_frame_decoder_core_test.sv
// self-checking testbench for the nec ir frame decoder core under random flow control
typedef logic [nec_ir_pkg::CODE_W-1:0] t_key_set [nec_ir_pkg::KEY_REGS];

localparam int KEYS_COMPARED = (nec_ir_pkg::NUM_KEYS_DEF < nec_ir_pkg::KEY_REGS)
                             ? nec_ir_pkg::NUM_KEYS_DEF : nec_ir_pkg::KEY_REGS;

class ir_key_scoreboard;
    t_key_set                          key_code;
    logic [nec_ir_pkg::HOLD_W-1:0]     hold_start;
    logic [nec_ir_pkg::PHASE_W-1:0]    dec_phase;
    logic [nec_ir_pkg::CNT_W-1:0]      bits_taken;
    logic [nec_ir_pkg::CODE_W-1:0]     bit_shift;
    logic                              key_flag;
    logic [nec_ir_pkg::WORD_W-1:0]     held_address;
    logic [nec_ir_pkg::WORD_W-1:0]     held_command;
    logic [nec_ir_pkg::HOLD_W-1:0]     hold_left;
    nec_ir_pkg::t_result               pending_keys [$];
    int                                mismatches;
    int                                results_checked;
    int                                frames_stored;
    int                                repeats_taken;
    int                                key_hits;
    int                                flag_drops;

    function new();
        key_code        = nec_ir_pkg::KEY_RESET;
        hold_start      = nec_ir_pkg::REPEAT_START_RST;
        go_idle();
        key_flag        = 1'b0;
        held_address    = '0;
        held_command    = '0;
        hold_left       = '0;
        mismatches      = 0;
        results_checked = 0;
        frames_stored   = 0;
        repeats_taken   = 0;
        key_hits        = 0;
        flag_drops      = 0;
    endfunction

    function void set_register(input logic [nec_ir_pkg::IDX_W-1:0] idx,
                               input logic [nec_ir_pkg::CODE_W-1:0] value);
        if (idx < nec_ir_pkg::KEY_REGS) begin
            key_code[idx] = value;
        end else if (idx == nec_ir_pkg::CFG_REPEAT_START) begin
            hold_start = value[nec_ir_pkg::HOLD_W-1:0];
        end
    endfunction

    function bit dur_open(input logic [nec_ir_pkg::DUR_W-1:0] d,
                          input logic [nec_ir_pkg::DUR_W-1:0] lo,
                          input logic [nec_ir_pkg::DUR_W-1:0] hi);
        return (d > lo) && (d < hi);
    endfunction

    function void go_idle();
        dec_phase  = nec_ir_pkg::PH_IDLE;
        bits_taken = '0;
        bit_shift  = '0;
    endfunction

    // lsb first, returns 1 once the frame is complete
    function bit push_bit(input logic b);
        if (bits_taken < 32) begin
            bit_shift[bits_taken[4:0]] = b;
        end
        if (bits_taken < 63) begin
            bits_taken = bits_taken + 1'b1;
        end
        return bits_taken >= nec_ir_pkg::FRAME_BITS_DEF;
    endfunction

    function logic [nec_ir_pkg::IDX_W-1:0] key_match();
        logic [nec_ir_pkg::CODE_W-1:0] code;
        code = {held_command, held_address};
        for (int k = 0; k < KEYS_COMPARED; k++) begin
            if (key_code[k] == code) begin
                return nec_ir_pkg::IDX_W'(k);
            end
        end
        return nec_ir_pkg::IDX_W'(KEYS_COMPARED);
    endfunction

    function void take_edge(input logic [nec_ir_pkg::DUR_W-1:0] d, input logic high);
        case (dec_phase)
            nec_ir_pkg::PH_LEAD: begin
                if (!high && dur_open(d, nec_ir_pkg::SPACE_LO, nec_ir_pkg::SPACE_HI)) begin
                    dec_phase = nec_ir_pkg::PH_SPACE;
                end else if (!high && dur_open(d, nec_ir_pkg::RSPACE_LO,
                                                nec_ir_pkg::RSPACE_HI)) begin
                    dec_phase = nec_ir_pkg::PH_RSPACE;
                end else begin
                    go_idle();
                end
            end
            nec_ir_pkg::PH_SPACE, nec_ir_pkg::PH_NEXT: begin
                // the countdown loads on leaving the space whatever the edge
                if (dec_phase == nec_ir_pkg::PH_SPACE) begin
                    hold_left = hold_start;
                end
                if (high && dur_open(d, nec_ir_pkg::SHORT_LO, nec_ir_pkg::SHORT_HI)) begin
                    dec_phase = nec_ir_pkg::PH_BITHEAD;
                end else begin
                    go_idle();
                end
            end
            nec_ir_pkg::PH_RSPACE: begin
                if (high && dur_open(d, nec_ir_pkg::SHORT_LO, nec_ir_pkg::SHORT_HI)) begin
                    hold_left = hold_start;
                    repeats_taken++;
                    go_idle();
                end
            end
            nec_ir_pkg::PH_BITHEAD: begin
                if (high) begin
                    go_idle();
                end else if (dur_open(d, nec_ir_pkg::ONE_LO, nec_ir_pkg::ONE_HI)) begin
                    dec_phase = push_bit(1'b1) ? nec_ir_pkg::PH_END : nec_ir_pkg::PH_NEXT;
                end else if (dur_open(d, nec_ir_pkg::SHORT_LO, nec_ir_pkg::SHORT_HI)) begin
                    dec_phase = push_bit(1'b0) ? nec_ir_pkg::PH_END : nec_ir_pkg::PH_NEXT;
                end else begin
                    go_idle();
                end
            end
            nec_ir_pkg::PH_END: begin
                if (high && dur_open(d, nec_ir_pkg::SHORT_LO, nec_ir_pkg::SHORT_HI)) begin
                    held_address = bit_shift[15:0];
                    held_command = bit_shift[31:16];
                    key_flag     = 1'b1;
                    frames_stored++;
                    if (key_match() != nec_ir_pkg::IDX_W'(KEYS_COMPARED)) begin
                        key_hits++;
                    end
                    go_idle();
                end
            end
            default: begin
                if (high && dur_open(d, nec_ir_pkg::LEAD_LO, nec_ir_pkg::LEAD_HI)) begin
                    dec_phase = nec_ir_pkg::PH_LEAD;
                end else begin
                    dec_phase = nec_ir_pkg::PH_IDLE;
                end
            end
        endcase
    endfunction

    function void note_event(input logic func, input logic [nec_ir_pkg::DUR_W-1:0] dur,
                             input logic pin);
        nec_ir_pkg::t_result exp;
        if (func) begin
            if (hold_left == 0) begin
                if (key_flag) begin
                    flag_drops++;
                end
                key_flag = 1'b0;
            end else begin
                hold_left = hold_left - 1'b1;
            end
            if (dec_phase != nec_ir_pkg::PH_IDLE) begin
                go_idle();
            end
        end else begin
            take_edge(dur, pin);
        end
        exp.key_available = key_flag;
        exp.key_held      = (hold_left != 0);
        exp.key_index     = key_match();
        exp.rx_address    = held_address;
        exp.rx_command    = held_command;
        pending_keys.push_back(exp);
    endfunction

    task report_mismatch(input string what, input logic [nec_ir_pkg::CODE_W-1:0] got,
                         input logic [nec_ir_pkg::CODE_W-1:0] want);
        $display("mismatch at result %0d: %s got %h expected %h",
                 results_checked, what, got, want);
        mismatches++;
    endtask

    task check_result(input nec_ir_pkg::t_result got);
        nec_ir_pkg::t_result exp;
        if (pending_keys.size() == 0) begin
            report_mismatch("result with no event outstanding",
                            nec_ir_pkg::CODE_W'(got), '0);
        end else begin
            exp = pending_keys.pop_front();
            results_checked++;
            if (got.key_available !== exp.key_available) begin
                report_mismatch("key_available", nec_ir_pkg::CODE_W'(got.key_available),
                                nec_ir_pkg::CODE_W'(exp.key_available));
            end
            if (got.key_held !== exp.key_held) begin
                report_mismatch("key_held", nec_ir_pkg::CODE_W'(got.key_held),
                                nec_ir_pkg::CODE_W'(exp.key_held));
            end
            if (got.key_index !== exp.key_index) begin
                report_mismatch("key_index", nec_ir_pkg::CODE_W'(got.key_index),
                                nec_ir_pkg::CODE_W'(exp.key_index));
            end
            if (got.rx_address !== exp.rx_address) begin
                report_mismatch("rx_address", nec_ir_pkg::CODE_W'(got.rx_address),
                                nec_ir_pkg::CODE_W'(exp.rx_address));
            end
            if (got.rx_command !== exp.rx_command) begin
                report_mismatch("rx_command", nec_ir_pkg::CODE_W'(got.rx_command),
                                nec_ir_pkg::CODE_W'(exp.rx_command));
            end
        end
    endtask
endclass

module nec_ir_frame_decoder_core_test;
    localparam int STALL_LIMIT  = 2000;
    localparam int LONG_HOLD    = 300;
    localparam int PHASE_EVENTS = 200;
    localparam int FRAME_EDGES  = 67;

    localparam logic [nec_ir_pkg::IDX_W-1:0] CFG_KEY_A = 3'd0;
    localparam logic [nec_ir_pkg::IDX_W-1:0] CFG_SPARE = 3'd7;

    logic                              i_clk = 1'b0;
    logic                              i_rst_n;
    logic                              i_in_valid;
    logic                              o_in_ready;
    logic                              i_func;
    logic [nec_ir_pkg::DUR_W-1:0]      i_duration_us;
    logic                              i_pin_level;
    logic                              o_out_valid;
    logic                              i_out_ready;
    logic                              o_key_available;
    logic                              o_key_held;
    logic [nec_ir_pkg::IDX_W-1:0]      o_key_index;
    logic [nec_ir_pkg::WORD_W-1:0]     o_rx_address;
    logic [nec_ir_pkg::WORD_W-1:0]     o_rx_command;
    logic                              i_cfg_valid;
    logic                              o_cfg_ready;
    logic [nec_ir_pkg::IDX_W-1:0]      i_cfg_index;
    logic [nec_ir_pkg::CODE_W-1:0]     i_cfg_data;

    ir_key_scoreboard sb;
    int in_gap_pct;
    int out_stall_pct;
    int events_sent;
    bit long_hold_request;

    always #5 i_clk = ~i_clk;

    nec_ir_frame_decoder_core DUT (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_in_valid      (i_in_valid),
        .o_in_ready      (o_in_ready),
        .i_func          (i_func),
        .i_duration_us   (i_duration_us),
        .i_pin_level     (i_pin_level),
        .o_out_valid     (o_out_valid),
        .i_out_ready     (i_out_ready),
        .o_key_available (o_key_available),
        .o_key_held      (o_key_held),
        .o_key_index     (o_key_index),
        .o_rx_address    (o_rx_address),
        .o_rx_command    (o_rx_command),
        .i_cfg_valid     (i_cfg_valid),
        .o_cfg_ready     (o_cfg_ready),
        .i_cfg_index     (i_cfg_index),
        .i_cfg_data      (i_cfg_data)
    );

    function automatic logic [nec_ir_pkg::DUR_W-1:0] pick_open(
        input logic [nec_ir_pkg::DUR_W-1:0] lo,
        input logic [nec_ir_pkg::DUR_W-1:0] hi
    );
        return nec_ir_pkg::DUR_W'($urandom_range(int'(lo) + 1, int'(hi) - 1));
    endfunction

    task automatic send_event(input logic func, input logic [nec_ir_pkg::DUR_W-1:0] dur,
                              input logic pin);
        while ($urandom_range(1, 100) <= in_gap_pct) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid    <= 1'b1;
        i_func        <= func;
        i_duration_us <= dur;
        i_pin_level   <= pin;
        do @(posedge i_clk); while (!o_in_ready);
        sb.note_event(func, dur, pin);
        events_sent++;
    endtask

    // duration and pin are don't-care on a tick, so keep them moving
    task automatic send_tick();
        send_event(1'b1, nec_ir_pkg::DUR_W'($urandom), 1'($urandom));
    endtask

    task automatic send_frame(input logic [nec_ir_pkg::CODE_W-1:0] word, input bit broken);
        logic [nec_ir_pkg::DUR_W-1:0] durs [FRAME_EDGES];
        logic                         pins [FRAME_EDGES];
        int                           bad;
        durs[0] = pick_open(nec_ir_pkg::LEAD_LO, nec_ir_pkg::LEAD_HI);
        pins[0] = 1'b1;
        durs[1] = pick_open(nec_ir_pkg::SPACE_LO, nec_ir_pkg::SPACE_HI);
        pins[1] = 1'b0;
        for (int b = 0; b < nec_ir_pkg::FRAME_BITS_DEF; b++) begin
            durs[2 + 2 * b] = pick_open(nec_ir_pkg::SHORT_LO, nec_ir_pkg::SHORT_HI);
            pins[2 + 2 * b] = 1'b1;
            durs[3 + 2 * b] = word[b] ? pick_open(nec_ir_pkg::ONE_LO, nec_ir_pkg::ONE_HI)
                                      : pick_open(nec_ir_pkg::SHORT_LO, nec_ir_pkg::SHORT_HI);
            pins[3 + 2 * b] = 1'b0;
        end
        durs[FRAME_EDGES - 1] = pick_open(nec_ir_pkg::SHORT_LO, nec_ir_pkg::SHORT_HI);
        pins[FRAME_EDGES - 1] = 1'b1;
        bad = broken ? $urandom_range(0, FRAME_EDGES - 1) : -1;
        for (int k = 0; k < FRAME_EDGES; k++) begin
            if (k == bad) begin
                case ($urandom_range(0, 3))
                    0: pins[k] = ~pins[k];
                    1: durs[k] = nec_ir_pkg::DUR_W'($urandom);
                    2: durs[k] = $urandom_range(0, 1) ? nec_ir_pkg::SHORT_LO
                                                      : nec_ir_pkg::SHORT_HI;
                    default: send_tick();
                endcase
            end
            send_event(1'b0, durs[k], pins[k]);
        end
    endtask

    task automatic send_repeat(input bit broken);
        send_event(1'b0, pick_open(nec_ir_pkg::LEAD_LO, nec_ir_pkg::LEAD_HI), 1'b1);
        send_event(1'b0, broken ? nec_ir_pkg::DUR_W'($urandom)
                                : pick_open(nec_ir_pkg::RSPACE_LO, nec_ir_pkg::RSPACE_HI),
                   1'b0);
        send_event(1'b0, pick_open(nec_ir_pkg::SHORT_LO, nec_ir_pkg::SHORT_HI), 1'b1);
    endtask

    task automatic run_traffic(input int count);
        int first;
        int pick;
        first = events_sent;
        while (events_sent - first < count) begin
            // a tick times out any half-received frame before the next burst
            if (sb.dec_phase != nec_ir_pkg::PH_IDLE) begin
                send_tick();
            end
            pick = $urandom_range(0, 99);
            if (pick < 55) begin
                send_frame($urandom_range(0, 1)
                           ? sb.key_code[$urandom_range(0, nec_ir_pkg::KEY_REGS - 1)]
                           : nec_ir_pkg::CODE_W'($urandom),
                           $urandom_range(0, 99) < 20);
            end else if (pick < 75) begin
                send_repeat($urandom_range(0, 99) < 20);
            end else if (pick < 90) begin
                repeat ($urandom_range(1, 14)) send_tick();
            end else begin
                repeat ($urandom_range(1, 6)) begin
                    send_event(1'($urandom), nec_ir_pkg::DUR_W'($urandom), 1'($urandom));
                end
            end
        end
    endtask

    task automatic drain();
        i_in_valid <= 1'b0;
        do @(posedge i_clk); while (sb.pending_keys.size() != 0);
    endtask

    task automatic write_register(input logic [nec_ir_pkg::IDX_W-1:0] idx,
                                  input logic [nec_ir_pkg::CODE_W-1:0] value);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= value;
        do @(posedge i_clk); while (!o_cfg_ready);
        sb.set_register(idx, value);
    endtask

    task automatic configure(input t_key_set keys,
                             input logic [nec_ir_pkg::HOLD_W-1:0] hold_value);
        logic [nec_ir_pkg::CODE_W-1:0] word;
        for (int k = 0; k < nec_ir_pkg::KEY_REGS; k++) begin
            write_register(CFG_KEY_A + nec_ir_pkg::IDX_W'(k), keys[k]);
        end
        word = $urandom;
        word[nec_ir_pkg::HOLD_W-1:0] = hold_value;
        write_register(nec_ir_pkg::CFG_REPEAT_START, word);
        write_register(CFG_SPARE, $urandom);
        i_cfg_valid <= 1'b0;
    endtask

    initial begin : result_monitor
        nec_ir_pkg::t_result got;
        i_out_ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (i_rst_n && o_out_valid && i_out_ready) begin
                got.key_available = o_key_available;
                got.key_held      = o_key_held;
                got.key_index     = o_key_index;
                got.rx_address    = o_rx_address;
                got.rx_command    = o_rx_command;
                sb.check_result(got);
            end
            if (long_hold_request) begin
                // long back-pressure so the output buffer fills and input stalls
                long_hold_request = 1'b0;
                i_out_ready <= 1'b0;
                repeat (LONG_HOLD) @(posedge i_clk);
            end
            i_out_ready <= ($urandom_range(1, 100) > out_stall_pct);
        end
    end

    initial begin : watchdog
        int quiet;
        quiet = 0;
        while (quiet < STALL_LIMIT) begin
            @(posedge i_clk);
            if ((i_in_valid && o_in_ready) || (o_out_valid && i_out_ready)
                    || (i_cfg_valid && o_cfg_ready)) begin
                quiet = 0;
            end else begin
                quiet++;
            end
        end
        $display("no transaction for %0d cycles", STALL_LIMIT);
        $display("nec_ir_frame_decoder_core_test failed");
        $finish;
    end

    initial begin : stimulus
        t_key_set keys;
        sb                = new();
        in_gap_pct        = 0;
        out_stall_pct     = 0;
        events_sent       = 0;
        long_hold_request = 1'b0;
        i_rst_n       <= 1'b0;
        i_in_valid    <= 1'b0;
        i_func        <= 1'b0;
        i_duration_us <= '0;
        i_pin_level   <= 1'b0;
        i_cfg_valid   <= 1'b0;
        i_cfg_index   <= CFG_KEY_A;
        i_cfg_data    <= '0;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed: window edges, repeat, mismatches and ticks with reset key codes
        send_tick();
        send_event(1'b0, 16'd0, 1'b0);
        send_event(1'b0, 16'hFFFF, 1'b1);
        send_event(1'b0, nec_ir_pkg::LEAD_LO, 1'b1);
        send_event(1'b0, nec_ir_pkg::LEAD_HI, 1'b1);
        send_event(1'b0, nec_ir_pkg::LEAD_LO + 1'b1, 1'b1);
        send_event(1'b0, nec_ir_pkg::SPACE_LO, 1'b0);
        send_event(1'b0, nec_ir_pkg::LEAD_HI - 1'b1, 1'b1);
        send_event(1'b0, nec_ir_pkg::RSPACE_HI - 1'b1, 1'b0);
        send_event(1'b0, nec_ir_pkg::SHORT_HI, 1'b1);
        send_event(1'b0, 16'd500, 1'b0);
        send_event(1'b0, nec_ir_pkg::SHORT_LO + 1'b1, 1'b1);
        send_tick();
        send_event(1'b0, 16'd9000, 1'b1);
        send_event(1'b0, nec_ir_pkg::SPACE_HI - 1'b1, 1'b0);
        send_event(1'b0, 16'd2000, 1'b1);
        send_event(1'b0, 16'd9000, 1'b1);
        send_event(1'b0, 16'd4500, 1'b0);
        send_event(1'b0, 16'd560, 1'b1);
        send_event(1'b0, 16'd560, 1'b1);
        send_event(1'b0, 16'd9000, 1'b1);
        send_event(1'b0, 16'd4500, 1'b0);
        send_event(1'b0, nec_ir_pkg::SHORT_HI - 1'b1, 1'b1);
        send_tick();
        send_event(1'b0, nec_ir_pkg::RSPACE_LO, 1'b0);
        run_traffic(PHASE_EVENTS);
        drain();

        // all-zero and all-one codes, a duplicate, and no hold time
        keys[0] = '0;
        keys[1] = '1;
        keys[2] = $urandom;
        keys[3] = $urandom;
        keys[4] = keys[2];
        keys[5] = $urandom;
        configure(keys, 8'd0);
        in_gap_pct = 53;
        run_traffic(PHASE_EVENTS);
        drain();

        for (int k = 0; k < nec_ir_pkg::KEY_REGS; k++) begin
            keys[k] = $urandom;
        end
        configure(keys, 8'hFF);
        in_gap_pct        = 0;
        out_stall_pct     = 53;
        long_hold_request = 1'b1;
        run_traffic(PHASE_EVENTS);
        drain();

        keys[0] = '1;
        for (int k = 1; k < nec_ir_pkg::KEY_REGS; k++) begin
            keys[k] = $urandom;
        end
        configure(keys, 8'd1);
        in_gap_pct    = 34;
        out_stall_pct = 34;
        run_traffic(PHASE_EVENTS);
        drain();

        for (int k = 0; k < nec_ir_pkg::KEY_REGS; k++) begin
            keys[k] = $urandom;
        end
        configure(keys, nec_ir_pkg::HOLD_W'($urandom_range(2, 30)));
        in_gap_pct    = 0;
        out_stall_pct = 0;
        run_traffic(PHASE_EVENTS);
        drain();
        repeat (4) @(posedge i_clk);

        if (sb.pending_keys.size() != 0) begin
            sb.report_mismatch("results never delivered", '0, sb.pending_keys.size());
        end
        $display("covered %0d events and %0d checked results over five register settings",
                 events_sent, sb.results_checked);
        $display("%0d frames stored, %0d naming a key, %0d repeats, %0d key timeouts",
                 sb.frames_stored, sb.key_hits, sb.repeats_taken, sb.flag_drops);
        if (sb.mismatches == 0) begin
            $display("nec_ir_frame_decoder_core_test passed");
        end else begin
            $display("nec_ir_frame_decoder_core_test failed");
        end
        $finish;
    end
endmodule
